FILE: sv/sptt_pkg.sv
`default_nettype none
package sptt_pkg;

   localparam int FRAC_BITS = 8;
   localparam int CW = 24;
   localparam int OW = 16;
   localparam int SW = 16;
   localparam int MW = 26;
   localparam int D2W = 2 * MW;
   localparam int LW = MW;
   localparam int NW = MW + SW + 1;
   localparam int QW = SW;
   localparam int RT_STAGES = LW;
   localparam int DV_STAGES = QW;

   localparam logic [D2W-1:0] HALF_SQ = D2W'(1) << (2 * FRAC_BITS - 2);
   localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

   localparam logic CSR_TARGET_Y_OFFSET = 1'b0;
   localparam logic CSR_BODY_Y_OFFSET   = 1'b1;

   typedef struct packed {
      logic signed [CW-1:0] hx;
      logic signed [CW-1:0] hy;
      logic [MW-1:0]        ax;
      logic [MW-1:0]        ay;
      logic                 sx;
      logic                 sy;
      logic                 moved;
      logic [SW-1:0]        spd;
   } ctx_type;

endpackage
`default_nettype wire

FILE: sv/step_point_toward_target.sv
// Pipeline from an accepted word to its result word: difference, square, sum, 26 root
// stages, numerator multiply, 16 divide stages, final add and output.
// Throughput: one word per cycle; the whole pipeline holds while the output word
// waits, set by the single shared advance enable.
// Reset: synchronous, active high; clears all valid bits and both offset registers.
`default_nettype none
module step_point_toward_target (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [sptt_pkg::CW-1:0] req_head_x,
   input  wire logic signed [sptt_pkg::CW-1:0] req_head_y,
   input  wire logic signed [sptt_pkg::CW-1:0] req_target_x,
   input  wire logic signed [sptt_pkg::CW-1:0] req_target_y,
   input  wire logic [sptt_pkg::SW-1:0]     req_step_speed,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [sptt_pkg::CW-1:0]   rsp_new_x,
   output logic signed [sptt_pkg::CW-1:0]   rsp_new_y,
   output logic signed [sptt_pkg::CW-1:0]   rsp_body_y,
   output logic                             rsp_moved,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_index,
   input  wire logic [sptt_pkg::OW-1:0]     csr_data
);

   localparam int CW  = sptt_pkg::CW;
   localparam int MW  = sptt_pkg::MW;
   localparam int D2W = sptt_pkg::D2W;
   localparam int LW  = sptt_pkg::LW;
   localparam int NW  = sptt_pkg::NW;
   localparam int QW  = sptt_pkg::QW;
   localparam int NR  = sptt_pkg::RT_STAGES;
   localparam int ND  = sptt_pkg::DV_STAGES;

   logic adv;
   logic signed [sptt_pkg::OW-1:0] toff_ff, boff_ff;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         toff_ff <= '0;
         boff_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            sptt_pkg::CSR_TARGET_Y_OFFSET: toff_ff <= csr_data;
            sptt_pkg::CSR_BODY_Y_OFFSET:   boff_ff <= csr_data;
            default:                       toff_ff <= toff_ff;
         endcase
      end
   end

   // difference and magnitude
   logic s1_vld_ff;
   sptt_pkg::ctx_type s1_ff, s1_in;
   logic signed [MW-1:0] dx, dy;

   always_comb begin
      dx = MW'(req_target_x) - MW'(req_head_x);
      dy = MW'(req_target_y) + MW'(toff_ff) - MW'(req_head_y);
      s1_in.hx    = req_head_x;
      s1_in.hy    = req_head_y;
      s1_in.sx    = dx[MW-1];
      s1_in.sy    = dy[MW-1];
      s1_in.ax    = dx[MW-1] ? MW'(-dx) : MW'(dx);
      s1_in.ay    = dy[MW-1] ? MW'(-dy) : MW'(dy);
      s1_in.moved = 1'b0;
      s1_in.spd   = req_step_speed;
   end

   // squares
   logic s2_vld_ff;
   sptt_pkg::ctx_type s2_ff;
   logic [D2W-1:0] sqx_ff, sqy_ff;

   // sum and threshold
   logic s3_vld_ff;
   sptt_pkg::ctx_type s3_ff, s3_in;
   logic [D2W-1:0] d2_ff;

   always_comb begin
      s3_in       = s2_ff;
      s3_in.moved = (sqx_ff + sqy_ff) > sptt_pkg::HALF_SQ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff          <= s1_in;
         s2_ff          <= s1_ff;
         sqx_ff         <= D2W'(s1_ff.ax) * D2W'(s1_ff.ax);
         sqy_ff         <= D2W'(s1_ff.ay) * D2W'(s1_ff.ay);
         s3_ff          <= s3_in;
         d2_ff          <= sqx_ff + sqy_ff;
      end
   end

   // square root, one result bit per stage
   logic              rt_vld_ff [NR];
   sptt_pkg::ctx_type rt_ctx_ff [NR];
   logic [D2W-1:0]    rt_rem_ff [NR];
   logic [LW-1:0]     rt_q_ff   [NR];

   for (genvar i = 0; i < NR; i++) begin : g_rt
      localparam int K = NR - 1 - i;
      logic              vld_src;
      sptt_pkg::ctx_type ctx_src;
      logic [D2W-1:0]    rem_src, trial;
      logic [LW-1:0]     q_src;

      if (i == 0) begin : g_head
         assign vld_src = s3_vld_ff;
         assign ctx_src = s3_ff;
         assign rem_src = d2_ff;
         assign q_src   = '0;
      end else begin : g_body
         assign vld_src = rt_vld_ff[i-1];
         assign ctx_src = rt_ctx_ff[i-1];
         assign rem_src = rt_rem_ff[i-1];
         assign q_src   = rt_q_ff[i-1];
      end

      assign trial = (D2W'(q_src) << (K + 1)) | (D2W'(1) << (2 * K));

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_vld_ff[i] <= 1'b0;
         end else if (adv) begin
            rt_vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rt_ctx_ff[i] <= ctx_src;
            if (rem_src >= trial) begin
               rt_rem_ff[i] <= rem_src - trial;
               rt_q_ff[i]   <= q_src | (LW'(1) << K);
            end else begin
               rt_rem_ff[i] <= rem_src;
               rt_q_ff[i]   <= q_src;
            end
         end
      end
   end

   // numerators with rounding half
   logic              mu_vld_ff;
   sptt_pkg::ctx_type mu_ctx_ff;
   logic [LW-1:0]     mu_len_ff;
   logic [NW-1:0]     mu_nx_ff, mu_ny_ff;
   logic [LW-1:0]     len_last;

   assign len_last = rt_q_ff[NR-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_vld_ff <= 1'b0;
      end else if (adv) begin
         mu_vld_ff <= rt_vld_ff[NR-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mu_ctx_ff <= rt_ctx_ff[NR-1];
         mu_len_ff <= len_last;
         mu_nx_ff  <= NW'(rt_ctx_ff[NR-1].ax) * NW'(rt_ctx_ff[NR-1].spd)
                      + NW'(len_last >> 1);
         mu_ny_ff  <= NW'(rt_ctx_ff[NR-1].ay) * NW'(rt_ctx_ff[NR-1].spd)
                      + NW'(len_last >> 1);
      end
   end

   // restoring divide, one quotient bit per stage for each axis
   logic              dv_vld_ff [ND];
   sptt_pkg::ctx_type dv_ctx_ff [ND];
   logic [LW-1:0]     dv_len_ff [ND];
   logic [NW-1:0]     dv_rx_ff  [ND];
   logic [NW-1:0]     dv_ry_ff  [ND];
   logic [QW-1:0]     dv_qx_ff  [ND];
   logic [QW-1:0]     dv_qy_ff  [ND];

   for (genvar j = 0; j < ND; j++) begin : g_dv
      localparam int K = ND - 1 - j;
      logic              vld_src;
      sptt_pkg::ctx_type ctx_src;
      logic [LW-1:0]     len_src;
      logic [NW-1:0]     rx_src, ry_src, dsh;
      logic [QW-1:0]     qx_src, qy_src;

      if (j == 0) begin : g_head
         assign vld_src = mu_vld_ff;
         assign ctx_src = mu_ctx_ff;
         assign len_src = mu_len_ff;
         assign rx_src  = mu_nx_ff;
         assign ry_src  = mu_ny_ff;
         assign qx_src  = '0;
         assign qy_src  = '0;
      end else begin : g_body
         assign vld_src = dv_vld_ff[j-1];
         assign ctx_src = dv_ctx_ff[j-1];
         assign len_src = dv_len_ff[j-1];
         assign rx_src  = dv_rx_ff[j-1];
         assign ry_src  = dv_ry_ff[j-1];
         assign qx_src  = dv_qx_ff[j-1];
         assign qy_src  = dv_qy_ff[j-1];
      end

      assign dsh = NW'(len_src) << K;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[j] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ctx_ff[j] <= ctx_src;
            dv_len_ff[j] <= len_src;
            if (rx_src >= dsh) begin
               dv_rx_ff[j] <= rx_src - dsh;
               dv_qx_ff[j] <= qx_src | (QW'(1) << K);
            end else begin
               dv_rx_ff[j] <= rx_src;
               dv_qx_ff[j] <= qx_src;
            end
            if (ry_src >= dsh) begin
               dv_ry_ff[j] <= ry_src - dsh;
               dv_qy_ff[j] <= qy_src | (QW'(1) << K);
            end else begin
               dv_ry_ff[j] <= ry_src;
               dv_qy_ff[j] <= qy_src;
            end
         end
      end
   end

   // final add, saturate, output word
   sptt_pkg::ctx_type fc;
   logic [QW-1:0]      fqx, fqy;
   logic signed [CW+1:0] sum_x, sum_y;
   logic signed [CW-1:0] nx, ny;
   logic signed [CW:0]   sum_b;
   logic signed [CW-1:0] nb;
   logic                 out_vld_ff;
   logic signed [CW-1:0] out_x_ff, out_y_ff, out_b_ff;
   logic                 out_m_ff;

   always_comb begin
      fc    = dv_ctx_ff[ND-1];
      fqx   = dv_qx_ff[ND-1];
      fqy   = dv_qy_ff[ND-1];
      sum_x = fc.sx ? (CW+2)'(fc.hx) - (CW+2)'({1'b0, fqx})
                    : (CW+2)'(fc.hx) + (CW+2)'({1'b0, fqx});
      sum_y = fc.sy ? (CW+2)'(fc.hy) - (CW+2)'({1'b0, fqy})
                    : (CW+2)'(fc.hy) + (CW+2)'({1'b0, fqy});
      if (!fc.moved)                                nx = fc.hx;
      else if (sum_x > (CW+2)'(sptt_pkg::COORD_MAX)) nx = sptt_pkg::COORD_MAX;
      else if (sum_x < (CW+2)'(sptt_pkg::COORD_MIN)) nx = sptt_pkg::COORD_MIN;
      else                                           nx = sum_x[CW-1:0];
      if (!fc.moved)                                ny = fc.hy;
      else if (sum_y > (CW+2)'(sptt_pkg::COORD_MAX)) ny = sptt_pkg::COORD_MAX;
      else if (sum_y < (CW+2)'(sptt_pkg::COORD_MIN)) ny = sptt_pkg::COORD_MIN;
      else                                           ny = sum_y[CW-1:0];
      sum_b = (CW+1)'(ny) + (CW+1)'(boff_ff);
      if (sum_b > (CW+1)'(sptt_pkg::COORD_MAX))      nb = sptt_pkg::COORD_MAX;
      else if (sum_b < (CW+1)'(sptt_pkg::COORD_MIN)) nb = sptt_pkg::COORD_MIN;
      else                                           nb = sum_b[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= dv_vld_ff[ND-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff <= nx;
         out_y_ff <= ny;
         out_b_ff <= nb;
         out_m_ff <= fc.moved;
      end
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_new_x  = out_x_ff;
   assign rsp_new_y  = out_y_ff;
   assign rsp_body_y = out_b_ff;
   assign rsp_moved  = out_m_ff;

   a_qx_bound: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[ND-1] && fc.moved |-> fqx <= fc.spd)
      else $error("x step above speed");

   a_qy_bound: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[ND-1] && fc.moved |-> fqy <= fc.spd)
      else $error("y step above speed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !mu_vld_ff)
      else $error("valid bits survive reset");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   localparam int CW = sptt_pkg::CW;
   localparam int SW = sptt_pkg::SW;
   localparam int OW = sptt_pkg::OW;
   localparam logic signed [CW-1:0] COORD_MAX = sptt_pkg::COORD_MAX;
   localparam logic signed [CW-1:0] COORD_MIN = sptt_pkg::COORD_MIN;

   localparam int LATENCY    = 47;
   localparam int WDOG_LIMIT = 20000;
   localparam int N_RANDOM   = 1400;

   typedef struct packed {
      logic signed [CW-1:0] hx;
      logic signed [CW-1:0] hy;
      logic signed [CW-1:0] tx;
      logic signed [CW-1:0] ty;
      logic [SW-1:0]        spd;
   } point_req_type;

   typedef struct packed {
      logic signed [CW-1:0] nx;
      logic signed [CW-1:0] ny;
      logic signed [CW-1:0] by;
      logic                 mv;
      logic                 chk;   // 1: typed-in value, 0: from stepper
   } point_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CW-1:0] req_head_x = '0, req_head_y = '0;
   logic signed [CW-1:0] req_target_x = '0, req_target_y = '0;
   logic [SW-1:0] req_step_speed = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [CW-1:0] rsp_new_x, rsp_new_y, rsp_body_y;
   logic rsp_moved;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = sptt_pkg::CSR_TARGET_Y_OFFSET;
   logic [OW-1:0] csr_data = '0;

   step_point_toward_target u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [OW-1:0] tgt_off = '0, body_off = '0;
   point_rsp_type expected_steps[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit hold_rx = 1'b0;
   int rx_gap_max = 16;

   function automatic logic signed [CW-1:0] clamp24(input longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return v[CW-1:0];
   endfunction

   function automatic longint root_floor(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint scaled_step(input longint d, input longint unsigned s,
                                          input longint unsigned len);
      longint unsigned m, q;
      m = d < 0 ? -d : d;
      q = (m * s + len / 2) / len;
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic point_rsp_type step_toward(input point_req_type p);
      point_rsp_type r;
      longint dx, dy, nx, ny, len;
      longint unsigned d2;
      dx = longint'(p.tx) - longint'(p.hx);
      dy = longint'(p.ty) + longint'(tgt_off) - longint'(p.hy);
      d2 = dx * dx + dy * dy;
      nx = p.hx;
      ny = p.hy;
      r.mv = d2 > longint'(sptt_pkg::HALF_SQ);
      if (r.mv) begin
         len = root_floor(d2);
         nx = clamp24(nx + scaled_step(dx, p.spd, len));
         ny = clamp24(ny + scaled_step(dy, p.spd, len));
      end
      r.nx = nx[CW-1:0];
      r.ny = ny[CW-1:0];
      r.by = clamp24(ny + longint'(body_off));
      r.chk = 1'b0;
      return r;
   endfunction

   task automatic send_point(input point_req_type p, input int gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_head_x, req_head_y, req_target_x, req_target_y, req_step_speed} <= p;
      expected_steps.push_back(step_toward(p));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_typed(input point_req_type p, input point_rsp_type e);
      point_rsp_type m;
      m = step_toward(p);
      send_point(p, 0);
      void'(expected_steps.pop_back());
      expected_steps.push_back(e);
      if (m.nx != e.nx || m.mv != e.mv) $display("typed row disagrees with stepper");
   endtask

   task automatic write_offsets(input logic [OW-1:0] tval, input logic [OW-1:0] bval);
      csr_valid <= 1'b1;
      csr_index <= sptt_pkg::CSR_TARGET_Y_OFFSET;
      csr_data  <= tval;
      do @(posedge clock); while (!csr_ready);
      tgt_off = tval;
      csr_index <= sptt_pkg::CSR_BODY_Y_OFFSET;
      csr_data  <= bval;
      do @(posedge clock); while (!csr_ready);
      body_off = bval;
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] rand_coord(input int mode);
      case (mode)
         0: return CW'($urandom);
         1: return CW'(COORD_MAX - $urandom_range(0, 4000));
         2: return CW'(COORD_MIN + $urandom_range(0, 4000));
         default: return CW'($signed($urandom_range(0, 20000)) - 10000);
      endcase
   endfunction

   function automatic point_req_type rand_point;
      point_req_type p;
      p.hx = rand_coord($urandom_range(0, 5));
      p.hy = rand_coord($urandom_range(0, 5));
      case ($urandom_range(0, 5))
         0: begin
            p.tx = CW'(p.hx + $signed($urandom_range(0, 256)) - 128);
            p.ty = CW'(p.hy + $signed($urandom_range(0, 256)) - 128);
         end
         1: begin
            p.tx = p.hx;
            p.ty = p.hy - tgt_off;
         end
         default: begin
            p.tx = rand_coord($urandom_range(0, 5));
            p.ty = rand_coord($urandom_range(0, 5));
         end
      endcase
      p.spd = ($urandom_range(0, 7) == 0) ? '1 : SW'($urandom);
      return p;
   endfunction

   // receive side
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (expected_steps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_new_x);
         end else begin
            point_rsp_type e;
            e = expected_steps.pop_front();
            if (e.nx !== rsp_new_x || e.ny !== rsp_new_y || e.by !== rsp_body_y
                || e.mv !== rsp_moved) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %h %h %h %b got %h %h %h %b", e.nx, e.ny, e.by,
                           e.mv, rsp_new_x, rsp_new_y, rsp_body_y, rsp_moved);
            end
         end
      end
   end

   initial begin
      int w;
      forever begin
         @(posedge clock);
         if (hold_rx) begin
            rsp_ready <= 1'b0;
         end else if (rsp_ready && rsp_valid) begin
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, rx_gap_max);
            if (w != 0) begin
               rsp_ready <= 1'b0;
               repeat (w) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || expected_steps.size() == 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      point_req_type p;
      point_rsp_type e;
      point_req_type dir_tab[$];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: coincident points stay put
      p = '{hx: 24'sd1000, hy: -24'sd500, tx: 24'sd1000, ty: -24'sd500, spd: 16'd256};
      e = '{nx: 24'sd1000, ny: -24'sd500, by: -24'sd500, mv: 1'b0, chk: 1'b1};
      send_typed(p, e);
      // exactly one half: not moved
      p = '{hx: 24'sd0, hy: 24'sd0, tx: 24'sd128, ty: 24'sd0, spd: 16'd256};
      e = '{nx: 24'sd0, ny: 24'sd0, by: 24'sd0, mv: 1'b0, chk: 1'b1};
      send_typed(p, e);
      // axis move, one pixel
      p = '{hx: 24'sd0, hy: 24'sd0, tx: 24'sd2560, ty: 24'sd0, spd: 16'd256};
      e = '{nx: 24'sd256, ny: 24'sd0, by: 24'sd0, mv: 1'b1, chk: 1'b1};
      send_typed(p, e);
      // zero speed
      p = '{hx: 24'sd7, hy: 24'sd9, tx: -24'sd3000, ty: 24'sd9, spd: 16'd0};
      e = '{nx: 24'sd7, ny: 24'sd9, by: 24'sd9, mv: 1'b1, chk: 1'b1};
      send_typed(p, e);
      // points at both coordinate ends, then short and diagonal distances
      p = '{hx: COORD_MAX, hy: COORD_MIN, tx: COORD_MIN, ty: COORD_MAX, spd: 16'hFFFF};
      dir_tab.push_back(p);
      p = '{hx: COORD_MIN, hy: COORD_MAX, tx: COORD_MAX, ty: COORD_MIN, spd: 16'hFFFF};
      dir_tab.push_back(p);
      p = '{hx: COORD_MAX - 24'sd10, hy: 24'sd0, tx: COORD_MAX, ty: 24'sd0, spd: 16'hFFFF};
      dir_tab.push_back(p);
      p = '{hx: COORD_MIN + 24'sd10, hy: COORD_MIN + 24'sd5, tx: COORD_MIN, ty: COORD_MIN,
            spd: 16'hFFFF};
      dir_tab.push_back(p);
      p = '{hx: 24'sd0, hy: 24'sd0, tx: 24'sd129, ty: 24'sd0, spd: 16'd100};
      dir_tab.push_back(p);
      p = '{hx: 24'sd0, hy: 24'sd0, tx: -24'sd91, ty: 24'sd91, spd: 16'd300};
      dir_tab.push_back(p);
      p = '{hx: 24'sd0, hy: 24'sd0, tx: -24'sd1, ty: -24'sd1, spd: 16'hFFFF};
      dir_tab.push_back(p);
      foreach (dir_tab[i]) send_point(dir_tab[i], $urandom_range(0, 2));
      drain();

      // offset extremes
      write_offsets(16'h7FFF, 16'h8000);
      p = '{hx: 24'sd0, hy: COORD_MIN, tx: 24'sd0, ty: COORD_MIN, spd: 16'd512};
      send_point(p, 0);
      p = '{hx: 24'sd5, hy: COORD_MAX, tx: 24'sd5, ty: COORD_MAX, spd: 16'hFFFF};
      send_point(p, 0);
      drain();
      write_offsets(16'h8000, 16'h7FFF);
      send_point(p, 0);
      p = '{hx: 24'sd0, hy: COORD_MIN, tx: 24'sd0, ty: COORD_MIN, spd: 16'd512};
      send_point(p, 0);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_offsets((ph == 0) ? 16'h0000 : 16'($urandom),
                       (ph == 4) ? 16'hFFFF : 16'($urandom));
         if (ph == 1) begin
            // hold the receiver so the pipeline fills and stalls its input
            hold_rx <= 1'b1;
            fork
               begin
                  repeat (300) @(posedge clock);
                  hold_rx <= 1'b0;
               end
               begin
                  for (int i = 0; i < 120; i++) send_point(rand_point(), 0);
                  req_valid <= 1'b0;
               end
            join
         end
         rx_gap_max = (ph == 3) ? 0 : 16;
         for (int i = 0; i < N_RANDOM / 5; i++) begin
            if (ph == 2 && i == 100) drain();
            send_point(rand_point(), ($urandom_range(0, 3) == 0 || ph == 3) ? 0
                                     : $urandom_range(0, 16));
         end
         drain();
      end

      if (mismatches == 0 && expected_steps.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
